>>> rtl/ets_pkg.sv
// Shared types, character constants and small helper functions for the
// expression token splitter. No dependencies; every other file imports it.
`default_nettype none

package ets_pkg;

    localparam int BYTE_W         = 8;
    localparam int DEPTH_W        = 8;
    localparam int HOLD_DEPTH_DEF = 32;

    localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] CH_LPAREN    = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN    = 8'h29;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_GT        = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_LT        = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_EQ        = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_PLUS      = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS     = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_STAR      = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_SLASH     = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;

    // Two-bit codes kept in the whitespace hold memory.
    localparam logic [1:0] BLANK_SPACE   = 2'd0;
    localparam logic [1:0] BLANK_TAB     = 2'd1;
    localparam logic [1:0] BLANK_NEWLINE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;          // an input byte is accepted this cycle
        logic out_char_now;  // load the input character as a result
        logic out_end;       // load a bare end marker
        logic start_flush;   // park the character and begin emitting held blanks
        logic emit_blank;    // load the next held blank as a result
        logic emit_pend;     // load the parked character as a result
    } t_ets_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_blank;      // input byte is whitespace
        logic need_flush;    // input character must be preceded by held blanks
        logic out_valid;     // output register holds a result
        logic flush_last;    // current held blank is the last one
        logic fl_nonzero;    // the flush count is not zero
    } t_ets_status;

    function automatic logic is_op(input logic [BYTE_W-1:0] c);
        return (c == CH_GT) || (c == CH_LT) || (c == CH_EQ) || (c == CH_PLUS) ||
               (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
    endfunction

    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
    endfunction

    function automatic logic [1:0] blank_code(input logic [BYTE_W-1:0] c);
        logic [1:0] code;
        case (c)
            CH_TAB:     code = BLANK_TAB;
            CH_NEWLINE: code = BLANK_NEWLINE;
            default:    code = BLANK_SPACE;
        endcase
        return code;
    endfunction

    function automatic logic [BYTE_W-1:0] blank_char(input logic [1:0] code);
        logic [BYTE_W-1:0] c;
        case (code)
            BLANK_TAB:     c = CH_TAB;
            BLANK_NEWLINE: c = CH_NEWLINE;
            default:       c = CH_SPACE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ets_ctrl.sv
// Controller state machine of the expression token splitter.
// Depends on ets_pkg for the command and status structs.
`default_nettype none

module ets_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_final_byte,
    input  wire logic                i_out_stall,
    input  wire ets_pkg::t_ets_status i_status,
    output logic                     o_in_stall,
    output ets_pkg::t_ets_cmd        o_cmd
);
    import ets_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_CHAR
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   slot_free;
    logic   take;

    assign slot_free  = !i_status.out_valid || !i_out_stall;
    assign take       = i_in_valid && (r_state == ST_IDLE) && slot_free;
    assign o_in_stall = !((r_state == ST_IDLE) && slot_free);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    o_cmd.take = 1'b1;
                    if (i_status.in_blank) begin
                        o_cmd.out_end = i_final_byte;
                    end else if (i_status.need_flush) begin
                        o_cmd.start_flush = 1'b1;
                        n_state           = ST_FLUSH;
                    end else begin
                        o_cmd.out_char_now = 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (slot_free) begin
                    o_cmd.emit_blank = 1'b1;
                    if (i_status.flush_last) begin
                        n_state = ST_CHAR;
                    end
                end
            end
            ST_CHAR: begin
                if (slot_free) begin
                    o_cmd.emit_pend = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A flush is only entered with at least one held blank.
    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> i_status.fl_nonzero)
        else $error("flush state with no held blanks");

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_char_now || o_cmd.out_end || o_cmd.emit_blank || o_cmd.emit_pend)
        |-> slot_free)
        else $error("result loaded while output register is stalled");

    // At most one result source is selected per cycle.
    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.out_char_now, o_cmd.out_end, o_cmd.emit_blank, o_cmd.emit_pend}))
        else $error("more than one result source selected");

endmodule

`default_nettype wire

>>> rtl/ets_dp.sv
// Datapath of the expression token splitter: tokenizer state, whitespace
// hold memory, flush counters and the output register. Depends on ets_pkg.
`default_nettype none

module ets_dp #(
    parameter int HOLD_DEPTH = ets_pkg::HOLD_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [ets_pkg::BYTE_W-1:0]  i_text_byte,
    input  wire logic                        i_final_byte,
    input  wire logic                        i_out_stall,
    input  wire ets_pkg::t_ets_cmd           i_cmd,
    output ets_pkg::t_ets_status             o_status,
    output logic                             o_out_valid,
    output logic [ets_pkg::BYTE_W-1:0]       o_out_byte,
    output logic                             o_byte_valid,
    output logic                             o_token_start,
    output logic                             o_blank_overflow,
    output logic                             o_run_last,
    output logic                             o_text_end
);
    import ets_pkg::*;

    localparam int CW = $clog2(HOLD_DEPTH + 1);
    localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    // Tokenizer state.
    logic               r_inside_quote;
    logic               r_backslash_odd;
    logic [DEPTH_W-1:0] r_paren_depth;
    logic               r_prev_may_end;
    logic               r_token_begun;
    logic [CW-1:0]      r_held_count;
    logic               r_held_overflow;

    // Hold memory and its registered read port.
    logic [1:0]         mem_blanks [HOLD_DEPTH];
    logic [1:0]         r_rd_data;

    // Flush bookkeeping and the parked character.
    logic [CW-1:0]      r_fl_idx;
    logic [CW-1:0]      r_fl_cnt;
    logic               r_fl_ovf;
    logic [BYTE_W-1:0]  r_pend_byte;
    logic               r_pend_fin;

    // Output register.
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_byte_valid;
    logic               r_token_start;
    logic               r_blank_overflow;
    logic               r_run_last;
    logic               r_text_end;

    logic               in_blank;
    logic               in_op;
    logic               held_nz;
    logic               boundary;
    logic               start_now;
    logic               n_inside_quote;
    logic               n_backslash_odd;
    logic [DEPTH_W-1:0] n_paren_depth;
    logic [CW-1:0]      n_fl_idx;
    logic               flush_last;
    logic               mem_we;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               out_load;

    assign in_blank  = is_blank(i_text_byte);
    assign in_op     = is_op(i_text_byte);
    assign held_nz   = (r_held_count != '0);
    assign boundary  = held_nz && r_prev_may_end && !in_op;
    assign start_now = !r_token_begun || boundary;

    assign n_fl_idx   = r_fl_idx + CW'(1);
    assign flush_last = (n_fl_idx == r_fl_cnt);

    assign o_status.in_blank   = in_blank;
    assign o_status.need_flush = r_token_begun && held_nz && !boundary;
    assign o_status.out_valid  = r_out_valid;
    assign o_status.flush_last = flush_last;
    assign o_status.fl_nonzero = (r_fl_cnt != '0);

    // Quote and parenthesis tracking for a non-blank character.
    always_comb begin
        n_inside_quote = r_inside_quote;
        if (i_text_byte == CH_QUOTE) begin
            if (!r_inside_quote) begin
                n_inside_quote = 1'b1;
            end else if (!r_backslash_odd) begin
                n_inside_quote = 1'b0;
            end
        end
        n_backslash_odd = (i_text_byte == CH_BACKSLASH) ? !r_backslash_odd : 1'b0;
        n_paren_depth   = r_paren_depth;
        if (!n_inside_quote) begin
            if ((i_text_byte == CH_LPAREN) && (r_paren_depth != '1)) begin
                n_paren_depth = r_paren_depth + DEPTH_W'(1);
            end else if ((i_text_byte == CH_RPAREN) && (r_paren_depth != '0)) begin
                n_paren_depth = r_paren_depth - DEPTH_W'(1);
            end
        end
    end

    assign mem_we  = i_cmd.take && in_blank && r_token_begun &&
                     (r_held_count < CW'(HOLD_DEPTH));
    assign rd_en   = i_cmd.start_flush || (i_cmd.emit_blank && !flush_last);
    assign rd_addr = i_cmd.start_flush ? '0 : n_fl_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_blanks[r_held_count[AW-1:0]] <= blank_code(i_text_byte);
        end
        if (rd_en) begin
            r_rd_data <= mem_blanks[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside_quote  <= 1'b0;
            r_backslash_odd <= 1'b0;
            r_paren_depth   <= '0;
            r_prev_may_end  <= 1'b0;
            r_token_begun   <= 1'b0;
            r_held_count    <= '0;
            r_held_overflow <= 1'b0;
        end else if (i_cmd.take) begin
            if (i_final_byte) begin
                r_inside_quote  <= 1'b0;
                r_backslash_odd <= 1'b0;
                r_paren_depth   <= '0;
                r_prev_may_end  <= 1'b0;
                r_token_begun   <= 1'b0;
                r_held_count    <= '0;
                r_held_overflow <= 1'b0;
            end else if (in_blank) begin
                r_backslash_odd <= 1'b0;
                if (r_token_begun) begin
                    if (r_held_count < CW'(HOLD_DEPTH)) begin
                        r_held_count <= r_held_count + CW'(1);
                    end else begin
                        r_held_overflow <= 1'b1;
                    end
                end
            end else begin
                r_inside_quote  <= n_inside_quote;
                r_backslash_odd <= n_backslash_odd;
                r_paren_depth   <= n_paren_depth;
                r_prev_may_end  <= (n_paren_depth == '0) && !n_inside_quote && !in_op;
                r_token_begun   <= 1'b1;
                r_held_count    <= '0;
                r_held_overflow <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_flush) begin
            r_fl_idx    <= '0;
            r_fl_cnt    <= r_held_count;
            r_fl_ovf    <= r_held_overflow;
            r_pend_byte <= i_text_byte;
            r_pend_fin  <= i_final_byte;
        end else if (i_cmd.emit_blank) begin
            r_fl_idx <= n_fl_idx;
        end
    end

    assign out_load = i_cmd.out_char_now || i_cmd.out_end ||
                      i_cmd.emit_blank || i_cmd.emit_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_char_now) begin
            r_out_byte       <= i_text_byte;
            r_byte_valid     <= 1'b1;
            r_token_start    <= start_now;
            r_blank_overflow <= 1'b0;
            r_run_last       <= 1'b1;
            r_text_end       <= i_final_byte;
        end else if (i_cmd.out_end) begin
            r_out_byte       <= '0;
            r_byte_valid     <= 1'b0;
            r_token_start    <= 1'b0;
            r_blank_overflow <= 1'b0;
            r_run_last       <= 1'b1;
            r_text_end       <= 1'b1;
        end else if (i_cmd.emit_blank) begin
            r_out_byte       <= blank_char(r_rd_data);
            r_byte_valid     <= 1'b1;
            r_token_start    <= 1'b0;
            r_blank_overflow <= r_fl_ovf;
            r_run_last       <= 1'b0;
            r_text_end       <= 1'b0;
        end else if (i_cmd.emit_pend) begin
            r_out_byte       <= r_pend_byte;
            r_byte_valid     <= 1'b1;
            r_token_start    <= 1'b0;
            r_blank_overflow <= r_fl_ovf;
            r_run_last       <= 1'b1;
            r_text_end       <= r_pend_fin;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_byte_valid     = r_byte_valid;
    assign o_token_start    = r_token_start;
    assign o_blank_overflow = r_blank_overflow;
    assign o_run_last       = r_run_last;
    assign o_text_end       = r_text_end;

    // The hold count never runs past the memory.
    a_hold_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_count <= CW'(HOLD_DEPTH))
        else $error("held blank count exceeds hold depth");

    // The last byte of a text leaves the tokenizer in its reset state.
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take && i_final_byte) |=>
        (!r_token_begun && (r_held_count == '0) && (r_paren_depth == '0) && !r_inside_quote))
        else $error("tokenizer state not cleared after final byte");

    // Blanks are only emitted while some remain to be flushed.
    a_flush_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_blank |-> (r_fl_idx < r_fl_cnt))
        else $error("blank emitted past the flush count");

endmodule

`default_nettype wire

>>> rtl/expression_token_splitter.sv
// Top level of the expression token splitter: joins the controller and the
// datapath. Depends on ets_pkg, ets_ctrl and ets_dp.
//
// Usage: expression text enters one byte per transfer on the input channel
// (i_in_valid / o_in_stall, payload i_text_byte and i_final_byte). Results
// leave on the output channel (o_out_valid / i_out_stall), one transfer per
// result: the token bytes with a token-start flag, held whitespace that sits
// inside a token, and a bare end marker when the last byte yields nothing.
// o_run_last marks the last result of an input byte, o_text_end the last
// result of the whole text.
// A byte that yields one result has it in the output register in the cycle
// after its transfer, so plain text flows at one byte per cycle while the
// receiver does not stall. A character that must be preceded by held blanks
// is taken in a transfer that reads the first held blank from the hold memory;
// the held blanks are then emitted, and the character after them. Input
// transfers pause while the held blanks drain.
// A whitespace byte that is held produces no result.
// Reset is synchronous and active low; it clears the tokenizer state, the
// controller and the output valid flag. The hold memory needs no clearing.
// When the receiver stalls, the waiting result holds still and the input
// stalls too until the output register can take another result.
`default_nettype none

module expression_token_splitter #(
    parameter int HOLD_DEPTH = ets_pkg::HOLD_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [ets_pkg::BYTE_W-1:0]  i_text_byte,
    input  wire logic                        i_final_byte,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [ets_pkg::BYTE_W-1:0]       o_out_byte,
    output logic                             o_byte_valid,
    output logic                             o_token_start,
    output logic                             o_blank_overflow,
    output logic                             o_run_last,
    output logic                             o_text_end
);
    import ets_pkg::*;

    t_ets_cmd    cmd;
    t_ets_status status;

    // The controller decides when to accept a byte and which result to load.
    ets_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_final_byte (i_final_byte),
        .i_out_stall  (i_out_stall),
        .i_status     (status),
        .o_in_stall   (o_in_stall),
        .o_cmd        (cmd)
    );

    // The datapath keeps the quote, backslash and depth tracking, the held
    // whitespace and the output register.
    ets_dp #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_text_byte      (i_text_byte),
        .i_final_byte     (i_final_byte),
        .i_out_stall      (i_out_stall),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_out_valid      (o_out_valid),
        .o_out_byte       (o_out_byte),
        .o_byte_valid     (o_byte_valid),
        .o_token_start    (o_token_start),
        .o_blank_overflow (o_blank_overflow),
        .o_run_last       (o_run_last),
        .o_text_end       (o_text_end)
    );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the expression token splitter: drives text bytes,
// predicts every token result in-house, and checks each output transfer.
// Depends on ets_pkg and the expression_token_splitter RTL only.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ets_pkg::*;

    // Hold depth of the whitespace memory; the predictor uses the same depth.
    localparam int HOLD         = HOLD_DEPTH_DEF;
    // Number of counted random bytes; leading blanks that vanish do not count.
    localparam int RANDOM_ITEMS = 260;
    // Cycles with no transfer on either channel before the run is given up.
    localparam int QUIET_LIMIT  = 1000;
    // Settling time after the last result.
    localparam int TAIL_CYCLES  = 16;

    // One result as it leaves the block.
    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       first;
        logic       overflow;
        logic       run_end;
        logic       text_done;
    } t_token_result;

    // Every input is known from time zero; reset starts asserted.
    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [7:0] i_text_byte  = 8'h00;
    logic       i_final_byte = 1'b0;
    logic       i_out_stall  = 1'b0;

    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_token_start;
    logic       o_blank_overflow;
    logic       o_run_last;
    logic       o_text_end;

    expression_token_splitter #(
        .HOLD_DEPTH(HOLD)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_text_byte     (i_text_byte),
        .i_final_byte    (i_final_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_token_start   (o_token_start),
        .o_blank_overflow(o_blank_overflow),
        .o_run_last      (o_run_last),
        .o_text_end      (o_text_end)
    );

    initial begin : clock_gen
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    // ------------------------------------------------------------------
    // Tokenizer state as the predictor sees it. Held whitespace is kept as
    // the characters themselves rather than as codes.
    // ------------------------------------------------------------------
    bit         in_literal;
    bit         escape_odd;
    logic [7:0] nest_depth;
    bit         may_split;
    bit         token_open;
    logic [7:0] held_blanks[$];
    bit         held_lost;

    // Results that are owed by the block, oldest first.
    t_token_result token_stream_q[$];

    // Stimulus controls and run statistics.
    bit         idle_en = 1'b1;
    logic [7:0] text_buf[$];
    int         fail_count;
    int         counted_items;
    int         bytes_sent;
    int         texts_sent;
    int         results_checked;
    int         token_starts;
    int         overflow_results;

    function automatic bit is_operator(input logic [7:0] c);
        case (c)
            CH_GT, CH_LT, CH_EQ, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        case (c)
            CH_SPACE, CH_TAB, CH_NEWLINE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_token_result make_result(input logic [7:0] ch, input logic has_char,
                                                  input logic first, input logic overflow);
        t_token_result r;
        r.ch        = ch;
        r.has_char  = has_char;
        r.first     = first;
        r.overflow  = overflow;
        r.run_end   = 1'b0;
        r.text_done = 1'b0;
        return r;
    endfunction

    function automatic void clear_tokenizer();
        in_literal = 1'b0;
        escape_odd = 1'b0;
        nest_depth = 8'd0;
        may_split  = 1'b0;
        token_open = 1'b0;
        held_blanks.delete();
        held_lost  = 1'b0;
    endfunction

    // Works out the results that one accepted byte causes and queues them.
    task automatic split_byte(input logic [7:0] c, input logic fin);
        t_token_result outs[$];
        bit            starts;
        bit            lost;
        if (is_blank(c)) begin
            // Whitespace never ends a token by itself; it is held only once a
            // token has begun, so leading blanks simply disappear.
            escape_odd = 1'b0;
            if (token_open) begin
                if (held_blanks.size() < HOLD) begin
                    held_blanks = {held_blanks, c};
                end else begin
                    held_lost = 1'b1;
                end
            end
        end else begin
            lost = 1'b0;
            if (!token_open) begin
                starts = 1'b1;
            end else if (held_blanks.size() > 0 && may_split && !is_operator(c)) begin
                // The held run is a token boundary and is dropped with any
                // overflow it may have had.
                starts = 1'b1;
            end else begin
                // The held run belongs to the token and comes out first.
                starts = 1'b0;
                lost   = held_lost;
                foreach (held_blanks[j]) begin
                    outs = {outs, make_result(held_blanks[j], 1'b1, 1'b0, lost)};
                end
            end
            held_blanks.delete();
            held_lost  = 1'b0;
            token_open = 1'b1;

            // A quote closes only when the backslash run before it is even.
            if (c == CH_QUOTE) begin
                if (!in_literal) begin
                    in_literal = 1'b1;
                end else if (!escape_odd) begin
                    in_literal = 1'b0;
                end
            end
            escape_odd = (c == CH_BACKSLASH) ? !escape_odd : 1'b0;
            if (!in_literal) begin
                if (c == CH_LPAREN && nest_depth != 8'hFF) begin
                    nest_depth = nest_depth + 8'd1;
                end else if (c == CH_RPAREN && nest_depth != 8'h00) begin
                    nest_depth = nest_depth - 8'd1;
                end
            end
            may_split = (nest_depth == 8'd0) && !in_literal && !is_operator(c);
            outs = {outs, make_result(c, 1'b1, starts, lost)};
        end

        // A final byte that yields no character still closes the text.
        if (fin && outs.size() == 0) begin
            outs = {outs, make_result(8'h00, 1'b0, 1'b0, 1'b0)};
        end
        if (outs.size() > 0) begin
            outs[outs.size()-1].run_end   = 1'b1;
            outs[outs.size()-1].text_done = fin;
        end
        if (fin) begin
            clear_tokenizer();
        end
        token_stream_q = {token_stream_q, outs};
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        t_token_result want;
        if (token_stream_q.size() == 0) begin
            $error("result byte 0x%0h arrived with nothing outstanding", o_out_byte);
            fail_count++;
        end else begin
            want = token_stream_q.pop_front();
            check_field("out_byte", want.ch, o_out_byte);
            check_field("byte_valid", 8'(want.has_char), 8'(o_byte_valid));
            check_field("token_start", 8'(want.first), 8'(o_token_start));
            check_field("blank_overflow", 8'(want.overflow), 8'(o_blank_overflow));
            check_field("run_last", 8'(want.run_end), 8'(o_run_last));
            check_field("text_end", 8'(want.text_done), 8'(o_text_end));
            results_checked++;
            if (want.first) token_starts++;
            if (want.overflow) overflow_results++;
        end
    endtask

    // Both channels are sampled at the rising edge, before any input driven
    // at that edge takes effect. A result can never come from the byte that
    // is accepted at the same edge, so checking before predicting is safe.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                check_result();
            end
            if (i_in_valid && !o_in_stall) begin
                split_byte(i_text_byte, i_final_byte);
            end
        end
    end

    // The receiver stalls in random bursts while idling is enabled.
    initial begin : receiver_stalls
        forever begin
            @(posedge i_clk);
            if (idle_en && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Ends the run if neither channel moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[expression_token_splitter] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Offers one byte and holds it until the block takes the transfer. A
    // random gap may follow; valid is only lowered when a gap really starts.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        i_in_valid   <= 1'b1;
        i_text_byte  <= b;
        i_final_byte <= fin;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // Sends the buffered text with the final flag on its last byte.
    task automatic send_text();
        bit seen_char;
        seen_char = 1'b0;
        foreach (text_buf[i]) begin
            if (!is_blank(text_buf[i])) seen_char = 1'b1;
            if (seen_char || i == text_buf.size() - 1) counted_items++;
            send_byte(text_buf[i], i == text_buf.size() - 1);
        end
        text_buf.delete();
        texts_sent++;
    endtask

    task automatic append_byte(input logic [7:0] b);
        text_buf = {text_buf, b};
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            append_byte(s[i]);
        end
    endtask

    task automatic add_blanks(input int n);
        repeat (n) begin
            case ($urandom_range(0, 2))
                0: append_byte(CH_SPACE);
                1: append_byte(CH_TAB);
                default: append_byte(CH_NEWLINE);
            endcase
        end
    endtask

    // Stops offering bytes until every owed result has been taken.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (token_stream_q.size() != 0);
    endtask

    // Builds a mostly well-formed expression: names, operators, parentheses,
    // quoted literals with escapes, whitespace runs and a little raw noise.
    // Unbalanced quotes and parentheses come up on their own.
    task automatic build_random_text();
        string ident_chars;
        string op_chars;
        string quoted_chars;
        int    parts;
        ident_chars  = "abxyz09_.";
        op_chars     = "><=+-*/";
        quoted_chars = "a \\\"(";
        if ($urandom_range(0, 4) == 0) add_blanks($urandom_range(1, 3));
        parts = $urandom_range(1, 14);
        for (int p = 0; p < parts; p++) begin
            case ($urandom_range(0, 11))
                0, 1, 2: begin
                    repeat ($urandom_range(1, 4)) begin
                        append_byte(ident_chars[$urandom_range(0, ident_chars.len() - 1)]);
                    end
                end
                3, 4: append_byte(op_chars[$urandom_range(0, op_chars.len() - 1)]);
                5: append_byte(CH_LPAREN);
                6: append_byte(CH_RPAREN);
                7: begin
                    append_byte(CH_QUOTE);
                    repeat ($urandom_range(0, 6)) begin
                        append_byte(quoted_chars[$urandom_range(0, quoted_chars.len() - 1)]);
                    end
                    if ($urandom_range(0, 3) != 0) append_byte(CH_QUOTE);
                end
                8, 9: add_blanks($urandom_range(1, 3));
                10: begin
                    // Now and then a run near or past the size of the hold memory.
                    if ($urandom_range(0, 7) == 0) add_blanks($urandom_range(HOLD - 2, HOLD + 8));
                    else add_blanks($urandom_range(1, 6));
                end
                default: append_byte(8'($urandom_range(0, 255)));
            endcase
        end
        if ($urandom_range(0, 3) == 0) add_blanks($urandom_range(1, 2));
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    task automatic test_directed();
        // Leading blanks vanish, a newline between names is a boundary, and
        // a trailing blank as the final byte leaves a bare end marker.
        add_str(" \ta\nb ");
        send_text();
        // Blanks next to an operator stay inside the token, on either side.
        add_str("x -\ty");
        send_text();
        // A closing parenthesis at depth zero keeps the depth at zero, so the
        // blank before c still splits; the blank inside the parentheses is kept.
        add_str(")(a b) c");
        send_text();
        // An escaped quote leaves the literal open; an even backslash run lets
        // the last quote close it.
        add_str("\"\\\" \\\\\"");
        send_text();
        // Extreme byte values as plain characters of a single token.
        append_byte(8'h00);
        append_byte(8'hFF);
        send_text();
    endtask

    task automatic test_hold_overflow();
        // Exactly a full hold memory before an operator: flushed, no overflow.
        add_str("w");
        add_blanks(HOLD);
        add_str("*");
        // Overflow before an operator and after one: flushed and flagged.
        add_str("x");
        add_blanks(HOLD + 8);
        add_str("+");
        add_blanks(HOLD + 3);
        add_str("y");
        // Overflow on a boundary: dropped silently.
        add_blanks(HOLD + 4);
        add_str("z");
        send_text();
    endtask

    task automatic test_paren_saturation();
        // The depth sticks at its top, so 255 closing parentheses bring it
        // back to zero and the blank between a and b becomes a boundary.
        repeat (257) append_byte(CH_LPAREN);
        repeat (255) append_byte(CH_RPAREN);
        add_str("a b");
        send_text();
    endtask

    task automatic test_random_texts();
        int first_item;
        int n_texts;
        first_item = counted_items;
        n_texts    = 0;
        while (counted_items - first_item < RANDOM_ITEMS) begin
            // Some texts run with no idling at all on either side.
            idle_en = ($urandom_range(0, 3) != 0);
            // Now and then the sender waits for the output to run dry.
            if (n_texts % 6 == 5) drain_results();
            build_random_text();
            send_text();
            n_texts++;
        end
    endtask

    task automatic test_full_rate();
        idle_en = 1'b0;
        repeat (4) begin
            build_random_text();
            send_text();
        end
    endtask

    initial begin : main
        fail_count       = 0;
        counted_items    = 0;
        bytes_sent       = 0;
        texts_sent       = 0;
        results_checked  = 0;
        token_starts     = 0;
        overflow_results = 0;
        clear_tokenizer();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_hold_overflow();
        test_paren_saturation();
        test_random_texts();
        test_full_rate();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (token_stream_q.size() != 0) begin
            $error("%0d results never arrived", token_stream_q.size());
            fail_count++;
        end

        $display("Covered %0d texts, %0d bytes: %0d results checked, %0d token starts.",
                 texts_sent, bytes_sent, results_checked, token_starts);
        $display("Included quote escapes, paren saturation and %0d results flagged for lost blanks.",
                 overflow_results);
        if (fail_count == 0) begin
            $display("[expression_token_splitter] OK");
        end else begin
            $display("[expression_token_splitter] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
